// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check an implication in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/bsdi_pkg.sv =====
// ----------------------------------------------------------------------------
// bsdi_pkg
// Types and constants of the brush stroke dab interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package bsdi_pkg;

  localparam int MAX_DABS = 64;
  localparam int DIV_W    = 48;

  localparam logic [2:0] REG_BASE   = 3'd0;
  localparam logic [2:0] REG_MIN    = 3'd1;
  localparam logic [2:0] REG_MAX    = 3'd2;
  localparam logic [2:0] REG_SPACE  = 3'd3;
  localparam logic [2:0] REG_WIDTH  = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;
  localparam logic [2:0] REG_ERASER = 3'd6;

  typedef struct packed {
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
    logic             start;
  } div_req_t;

  typedef struct packed {
    logic [DIV_W-1:0] quo;
    logic             busy;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/bsdi_divider.sv =====
// ----------------------------------------------------------------------------
// bsdi_divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bsdi_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bsdi_pkg::div_req_t req,
  output bsdi_pkg::div_rsp_t     rsp
);
  import bsdi_pkg::*;

  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] den;
  logic [5:0]       cnt;
  logic             busy;
  logic [DIV_W:0]   trial;

  assign trial = {rem, quo[DIV_W-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= 6'(DIV_W);
      quo  <= req.num;
      rem  <= '0;
      den  <= req.den;
    end else if (busy) begin
      if (!trial[DIV_W]) begin
        rem <= trial[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DIV_W-2:0], quo[DIV_W-1]};
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  assign rsp = {quo, busy};

endmodule

`default_nettype wire

// ===== rtl/brush_stroke_dab_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// brush_stroke_dab_interpolator_unit
// Turns stroke points into spaced brush dabs in device coordinates.
// ----------------------------------------------------------------------------
// Usage:
// An input item (point_x, point_y, pen_pressure, stroke_start) is taken when
// in_valid is high and in_stall low. The block then holds in_stall high
// until every dab of that point has been taken on the output channel.
// Each dab appears with out_valid; it is taken when out_stall is low.
// last_dab marks the final dab of a point; a point that gives no dab gives
// no output item. All divisions go through one shared 48-bit serial divider.
// A later point takes the square root of its squared distance and divides it
// by the spacing; a point that gives dabs then divides for the two half sizes
// (where the first point of a stroke starts) and for the centre x and y of each
// dab, redoing the centre divisions after each dab but the last is taken. The
// next point can be taken in the cycle after the last dab is taken. A stall of
// the receiver holds the dab in the output register and stops the sequencer.
// Reset restores register defaults and forgets the stored point. The user must
// write registers over the APB port while the block is idle; this is not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module brush_stroke_dab_interpolator_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] point_x,
  input  wire logic [15:0] point_y,
  input  wire logic [8:0]  pen_pressure,
  input  wire logic        stroke_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [15:0] quad_left,
  output logic signed [15:0] quad_right,
  output logic signed [15:0] quad_bottom,
  output logic signed [15:0] quad_top,
  output logic [8:0]       dab_alpha,
  output logic             last_dab
);
  import bsdi_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_SQINIT, S_SQRT, S_NGO, S_NWAIT, S_HWGO, S_HWWAIT, S_HHGO,
    S_HHWAIT, S_CXGO, S_CXWAIT, S_CYGO, S_CYWAIT, S_OUT
  } state_t;

  logic [11:0] base_size, min_size, max_size, spacing;
  logic [12:0] canvas_width, canvas_height;
  logic        eraser_mode;

  state_t      state;
  logic [15:0] prev_x, prev_y;
  logic        have_prev;
  logic [15:0] bx, by;
  logic signed [16:0] dx, dy;
  logic [6:0]  n, i;
  logic [8:0]  p;
  logic [31:0] hw, hh;
  logic signed [33:0] cx;
  logic [33:0] sq_v;
  logic [33:0] sq_r;
  logic [33:0] sq_bit;
  logic [12:0] w, h;
  logic        div_go;
  div_req_t    req;
  div_rsp_t    rsp;
  logic [DIV_W-1:0] div_num, div_den;

  logic        wr;
  logic [2:0]  ridx;
  logic [15:0] adx, ady;
  logic [31:0] dx2, dy2;
  logic [33:0] d2;
  logic [33:0] sq_sum;
  logic [8:0]  pc;
  logic [20:0] ps;
  logic [11:0] s_raw, s_lo, s_val, sp;
  logic [22:0] bxn, byn;
  logic signed [23:0] dxi, dyi;
  logic signed [24:0] posx, posy;
  logic [19:0] nw, nh;
  logic signed [34:0] e0, e1, e2, e3;
  logic signed [34:0] cy_val;
  logic [6:0]  nsat;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = paddr[4:2];
  assign w      = (canvas_width == 13'd0) ? 13'd1 : canvas_width;
  assign h      = (canvas_height == 13'd0) ? 13'd1 : canvas_height;
  assign sp     = (spacing == 12'd0) ? 12'd1 : spacing;

  always_comb begin
    prdata = '0;
    unique case (ridx)
      REG_BASE:   prdata = {20'd0, base_size};
      REG_MIN:    prdata = {20'd0, min_size};
      REG_MAX:    prdata = {20'd0, max_size};
      REG_SPACE:  prdata = {20'd0, spacing};
      REG_WIDTH:  prdata = {19'd0, canvas_width};
      REG_HEIGHT: prdata = {19'd0, canvas_height};
      REG_ERASER: prdata = {31'd0, eraser_mode};
      default:    prdata = '0;
    endcase
  end

  bsdi_divider u_div (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  assign pc    = (pen_pressure > 9'd256) ? 9'd256 : pen_pressure;
  assign ps    = {12'd0, p} * {9'd0, base_size};
  assign s_raw = ps[19:8];
  assign s_lo  = (s_raw < min_size) ? min_size : s_raw;
  assign s_val = (s_lo > max_size) ? max_size : s_lo;

  assign adx    = dx[16] ? 16'(-dx) : dx[15:0];
  assign ady    = dy[16] ? 16'(-dy) : dy[15:0];
  assign dx2    = {16'd0, adx} * {16'd0, adx};
  assign dy2    = {16'd0, ady} * {16'd0, ady};
  assign d2     = {2'd0, dx2} + {2'd0, dy2};
  assign sq_sum = sq_r + sq_bit;

  assign bxn  = {7'd0, bx} * {16'd0, n};
  assign byn  = {7'd0, by} * {16'd0, n};
  assign dxi  = 24'(dx) * $signed({17'd0, i});
  assign dyi  = 24'(dy) * $signed({17'd0, i});
  assign posx = $signed({2'd0, bxn}) + 25'(dxi);
  assign posy = $signed({2'd0, byn}) + 25'(dyi);
  assign nw   = {7'd0, w} * {13'd0, n};
  assign nh   = {7'd0, h} * {13'd0, n};

  assign cy_val = 35'sd16384 - $signed({1'b0, rsp.quo[33:0]});
  assign e0 = 35'(cx) - $signed({3'd0, hw});
  assign e1 = 35'(cx) + $signed({3'd0, hw});
  assign e2 = cy_val - $signed({3'd0, hh});
  assign e3 = cy_val + $signed({3'd0, hh});
  assign nsat = (rsp.quo > 48'(MAX_DABS)) ? 7'(MAX_DABS) : rsp.quo[6:0];

  assign div_go = (state == S_NGO) || (state == S_HWGO) || (state == S_HHGO) ||
                  (state == S_CXGO) || (state == S_CYGO);

  always_comb begin
    div_num = '0;
    div_den = '0;
    unique case (state)
      S_NGO: begin
        div_num = {31'd0, sq_r[16:0]};
        div_den = {36'd0, sp};
      end
      S_HWGO: begin
        div_num = {25'd0, s_val, 11'd0};
        div_den = {35'd0, w};
      end
      S_HHGO: begin
        div_num = {25'd0, s_val, 11'd0};
        div_den = {35'd0, h};
      end
      S_CXGO: begin
        div_num = {15'd0, posx[21:0], 11'd0};
        div_den = {28'd0, nw};
      end
      S_CYGO: begin
        div_num = {15'd0, posy[21:0], 11'd0};
        div_den = {28'd0, nh};
      end
      default: ;
    endcase
  end

  assign req = {div_num, div_den, div_go};

  function automatic logic [15:0] sat16(input logic signed [34:0] v);
    if (v > 35'sd32767) return 16'h7FFF;
    if (v < -35'sd32768) return 16'h8000;
    return v[15:0];
  endfunction

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_size <= 12'd160; min_size <= 12'd16; max_size <= 12'd1600;
      spacing <= 12'd32; canvas_width <= 13'd1024; canvas_height <= 13'd1024;
      eraser_mode <= 1'b0;
      state <= S_IDLE; prev_x <= '0; prev_y <= '0; have_prev <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (wr) begin
        unique case (ridx)
          REG_BASE:   base_size <= pwdata[11:0];
          REG_MIN:    min_size <= pwdata[11:0];
          REG_MAX:    max_size <= pwdata[11:0];
          REG_SPACE:  spacing <= pwdata[11:0];
          REG_WIDTH:  canvas_width <= pwdata[12:0];
          REG_HEIGHT: canvas_height <= pwdata[12:0];
          REG_ERASER: eraser_mode <= pwdata[0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (in_valid) begin
          p <= pc;
          prev_x <= point_x; prev_y <= point_y; have_prev <= 1'b1;
          if (stroke_start || !have_prev) begin
            bx <= point_x; by <= point_y; dx <= '0; dy <= '0; n <= 7'd1;
            state <= S_HWGO;
          end else begin
            bx <= prev_x; by <= prev_y;
            dx <= $signed({1'b0, point_x}) - $signed({1'b0, prev_x});
            dy <= $signed({1'b0, point_y}) - $signed({1'b0, prev_y});
            state <= S_SQINIT;
          end
        end
        S_SQINIT: begin
          sq_v <= d2;
          sq_r <= '0;
          sq_bit <= 34'h1_0000_0000;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_bit == '0) begin
            state <= S_NGO;
          end else begin
            if (sq_v >= sq_sum) begin
              sq_v <= sq_v - sq_sum;
              sq_r <= (sq_r >> 1) + sq_bit;
            end else begin
              sq_r <= sq_r >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
        end
        S_NGO: state <= S_NWAIT;
        S_NWAIT: if (!rsp.busy) begin
          n <= nsat;
          state <= (nsat == 7'd0) ? S_IDLE : S_HWGO;
        end
        S_HWGO: state <= S_HWWAIT;
        S_HWWAIT: if (!rsp.busy) begin
          hw <= rsp.quo[31:0];
          state <= S_HHGO;
        end
        S_HHGO: state <= S_HHWAIT;
        S_HHWAIT: if (!rsp.busy) begin
          hh <= rsp.quo[31:0];
          i <= 7'd1;
          state <= S_CXGO;
        end
        S_CXGO: state <= S_CXWAIT;
        S_CXWAIT: if (!rsp.busy) begin
          cx <= $signed({1'b0, rsp.quo[32:0]}) - 34'sd16384;
          state <= S_CYGO;
        end
        S_CYGO: state <= S_CYWAIT;
        S_CYWAIT: if (!rsp.busy) begin
          quad_left <= sat16(e0); quad_right <= sat16(e1);
          quad_bottom <= sat16(e2); quad_top <= sat16(e3);
          dab_alpha <= eraser_mode ? p : (p >> 1);
          last_dab <= (i == n);
          out_valid <= 1'b1; state <= S_OUT;
        end
        S_OUT: if (!out_stall) begin
          out_valid <= 1'b0;
          if (i == n) state <= S_IDLE;
          else begin
            i <= i + 7'd1; state <= S_CXGO;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_out_busy, clk, rst, out_valid, state == S_OUT)
  `ASSERT_IMPL(a_idx, clk, rst, state == S_OUT, i <= n && i != 0)
  `ASSERT_NEXT(a_go_busy, clk, rst, div_go, rsp.busy)

endmodule

`default_nettype wire
